@@ hdl/sequence_step_timeout_watchdog_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sequence step timeout watchdog
// Clocked implication helpers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SEQUENCE_STEP_TIMEOUT_WATCHDOG_UNIT_ASSERT_SVH
`define SEQUENCE_STEP_TIMEOUT_WATCHDOG_UNIT_ASSERT_SVH

// same-cycle implication
`define SSTW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sstw assertion failed");

// next-cycle implication
`define SSTW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sstw assertion failed");

`endif

@@ hdl/sstw_pkg.sv @@
// ----------------------------------------------------------------------------
// sstw_pkg
// Types and constants shared by the sequence step timeout watchdog.
// ----------------------------------------------------------------------------
package sstw_pkg;

  localparam int LIMIT_W   = 20;
  localparam int NUM_STEPS = 5;
  localparam int CFG_IDX_W = 3;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd5000;

  typedef enum logic [2:0] {
    OP_EVENT     = 3'd0,
    OP_TICK      = 3'd1,
    OP_REMOTE    = 3'd2,
    OP_CLR_EMERG = 3'd3,
    OP_TEST      = 3'd4,
    OP_CLR_TEST  = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    EV_DETECT = 3'd0,
    EV_STOP   = 3'd1,
    EV_OPEN   = 3'd2,
    EV_PASS   = 3'd3,
    EV_CLOSE  = 3'd4,
    EV_RESUME = 3'd5,
    EV_FAULT  = 3'd6,
    EV_OTHER  = 3'd7
  } ev_e;

  localparam logic [2:0] NO_STEP = 3'd7;

  typedef enum logic [2:0] {
    CAUSE_NONE    = 3'd0,
    CAUSE_TIMEOUT = 3'd1,
    CAUSE_FAULT   = 3'd2,
    CAUSE_REMOTE  = 3'd3,
    CAUSE_TEST    = 3'd4
  } cause_e;

  localparam logic [CFG_IDX_W-1:0] REG_SIM_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_DETECT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_CLOSE  = 3'd5;

  typedef struct packed {
    logic [2:0] operation;
    logic [2:0] event_code;
  } in_t;

  typedef struct packed {
    logic       emergency_active;
    logic       safe_state_entered;
    logic [2:0] fault_cause;
    logic [2:0] stalled_step;
    logic       normal_restored;
    logic       test_fault_active;
    logic       monitor_armed;
  } out_t;

  typedef struct packed {
    logic                              simulation_mode;
    logic [NUM_STEPS-1:0][LIMIT_W-1:0] limits;
  } cfg_t;

endpackage

@@ hdl/sstw_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// sstw_cfg_regs
// Configuration register file: simulation mode and the five step limits.
// ----------------------------------------------------------------------------
module sstw_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sstw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sstw_pkg::LIMIT_W-1:0]   cfg_data_i,
  output sstw_pkg::cfg_t                 cfg_o
);
  import sstw_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;
  logic [CFG_IDX_W-1:0] lim_idx;

  assign cfg_ready_o = 1'b1;
  assign lim_idx     = cfg_index_i - REG_LIMIT_DETECT;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      if (cfg_index_i == REG_SIM_MODE) begin
        cfg_d.simulation_mode = cfg_data_i[0];
      end else if (cfg_index_i inside {[REG_LIMIT_DETECT:REG_LIMIT_CLOSE]}) begin
        cfg_d.limits[lim_idx] = cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.simulation_mode <= 1'b1;
      cfg_q.limits          <= {NUM_STEPS{LIMIT_RESET}};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/sstw_core.sv @@
// ----------------------------------------------------------------------------
// sstw_core
// Watchdog state and the single-pass update for one word.
// ----------------------------------------------------------------------------
module sstw_core #(
  parameter int TICK_BITS      = 20,
  parameter int FALLBACK_LIMIT = 5000
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_en_i,
  input  sstw_pkg::in_t  item_i,
  input  sstw_pkg::cfg_t cfg_i,
  output sstw_pkg::out_t res_o
);
  import sstw_pkg::*;

  localparam int CMP_W = (TICK_BITS > LIMIT_W) ? TICK_BITS : LIMIT_W;

  logic [2:0]           last_q, last_d;
  logic                 armed_q, armed_d;
  logic [TICK_BITS-1:0] elapsed_q, elapsed_d;
  logic                 emerg_q, emerg_d;
  logic                 test_q, test_d;
  logic [2:0]           cause_q, cause_d;

  logic [TICK_BITS-1:0] elapsed_inc;
  logic [LIMIT_W-1:0]   step_limit;
  logic                 over_limit;
  logic                 raise_req;
  cause_e               raise_cause;
  logic                 entered;
  logic [2:0]           stalled;
  logic                 restored;

  assign elapsed_inc = (elapsed_q != {TICK_BITS{1'b1}}) ? elapsed_q + TICK_BITS'(1) : elapsed_q;
  assign step_limit  = (last_q < 3'(NUM_STEPS)) ? cfg_i.limits[last_q]
                                                : LIMIT_W'(FALLBACK_LIMIT);
  assign over_limit  = CMP_W'(elapsed_inc) > CMP_W'(step_limit);

  always_comb begin
    last_d      = last_q;
    armed_d     = armed_q;
    elapsed_d   = elapsed_q;
    emerg_d     = emerg_q;
    test_d      = test_q;
    cause_d     = cause_q;
    raise_req   = 1'b0;
    raise_cause = CAUSE_NONE;
    entered     = 1'b0;
    stalled     = NO_STEP;
    restored    = 1'b0;

    case (item_i.operation)
      OP_EVENT: begin
        if (item_i.event_code == EV_DETECT) begin
          last_d    = EV_DETECT;
          armed_d   = 1'b1;
          elapsed_d = '0;
        end else if (item_i.event_code inside {[EV_STOP:EV_CLOSE]}) begin
          if (last_q == item_i.event_code - 3'd1) begin
            armed_d = 1'b0;
          end else begin
            last_d    = item_i.event_code;
            armed_d   = 1'b1;
            elapsed_d = '0;
          end
        end else if (item_i.event_code == EV_RESUME) begin
          if (last_q == EV_CLOSE) begin
            armed_d = 1'b0;
          end
        end else if (item_i.event_code == EV_FAULT) begin
          raise_req   = 1'b1;
          raise_cause = CAUSE_FAULT;
        end
      end
      OP_TICK: begin
        if (armed_q) begin
          elapsed_d = elapsed_inc;
          if (!cfg_i.simulation_mode && !emerg_q && over_limit) begin
            raise_req   = 1'b1;
            raise_cause = CAUSE_TIMEOUT;
            stalled     = last_q;
            armed_d     = 1'b0;
          end
        end
      end
      OP_REMOTE: begin
        raise_req   = 1'b1;
        raise_cause = CAUSE_REMOTE;
      end
      OP_CLR_EMERG: begin
        emerg_d = 1'b0;
        cause_d = CAUSE_NONE;
      end
      OP_TEST: begin
        if (!test_q) begin
          test_d      = 1'b1;
          raise_req   = 1'b1;
          raise_cause = CAUSE_TEST;
        end
      end
      OP_CLR_TEST: begin
        if (test_q) begin
          test_d   = 1'b0;
          emerg_d  = 1'b0;
          cause_d  = CAUSE_NONE;
          restored = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (raise_req && !emerg_q) begin
      emerg_d = 1'b1;
      cause_d = raise_cause;
      entered = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q    <= NO_STEP;
      armed_q   <= 1'b0;
      elapsed_q <= '0;
      emerg_q   <= 1'b0;
      test_q    <= 1'b0;
      cause_q   <= CAUSE_NONE;
    end else if (step_en_i) begin
      last_q    <= last_d;
      armed_q   <= armed_d;
      elapsed_q <= elapsed_d;
      emerg_q   <= emerg_d;
      test_q    <= test_d;
      cause_q   <= cause_d;
    end
  end

  always_comb begin
    res_o.emergency_active   = emerg_d;
    res_o.safe_state_entered = entered;
    res_o.fault_cause        = cause_d;
    res_o.stalled_step       = stalled;
    res_o.normal_restored    = restored;
    res_o.test_fault_active  = test_d;
    res_o.monitor_armed      = armed_d;
  end

endmodule

@@ hdl/sequence_step_timeout_watchdog_unit.sv @@
// ----------------------------------------------------------------------------
// sequence_step_timeout_watchdog_unit
// Words pass the input register, the state update and the result reg.
// Throughput: one word per cycle while out_ready_i does not stall output.
// Reset: rst_ni clears state at once, no step monitored, simulation mode on.
// ----------------------------------------------------------------------------
module sequence_step_timeout_watchdog_unit #(
  parameter int TICK_BITS      = 20,
  parameter int FALLBACK_LIMIT = 5000
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  sstw_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output sstw_pkg::out_t                 out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sstw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sstw_pkg::LIMIT_W-1:0]   cfg_data_i
);
  import sstw_pkg::*;

  logic in_valid_q;
  in_t  in_data_q;
  logic out_valid_q;
  out_t out_data_q;
  logic advance;
  cfg_t cfg;
  out_t res;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  sstw_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  sstw_core #(
    .TICK_BITS      (TICK_BITS),
    .FALLBACK_LIMIT (FALLBACK_LIMIT)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (advance),
    .item_i    (in_data_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ hdl/sstw_checker.sv @@
// ----------------------------------------------------------------------------
// sstw_checker
// Port-level checks on the watchdog results, bound to the top level.
// ----------------------------------------------------------------------------
`include "sequence_step_timeout_watchdog_unit_assert.svh"

module sstw_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input sstw_pkg::out_t out_data_o
);
  import sstw_pkg::*;

  `SSTW_ASSERT_IMP(a_entered_latched, clk_i, rst_ni,
                   out_valid_o && out_data_o.safe_state_entered,
                   out_data_o.emergency_active)
  `SSTW_ASSERT_IMP(a_cause_matches, clk_i, rst_ni, out_valid_o,
                   out_data_o.emergency_active == (out_data_o.fault_cause != CAUSE_NONE))
  `SSTW_ASSERT_IMP(a_stall_is_timeout, clk_i, rst_ni,
                   out_valid_o && (out_data_o.stalled_step != NO_STEP),
                   out_data_o.safe_state_entered &&
                   (out_data_o.fault_cause == CAUSE_TIMEOUT) &&
                   !out_data_o.monitor_armed)
  `SSTW_ASSERT_IMP(a_restore_clears, clk_i, rst_ni,
                   out_valid_o && out_data_o.normal_restored,
                   !out_data_o.emergency_active && !out_data_o.test_fault_active)
  `SSTW_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(out_data_o))

endmodule

bind sequence_step_timeout_watchdog_unit sstw_checker u_sstw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
